>>> rtl/core/pcrt_pkg.sv
package pcrt_pkg;

  localparam int FIELD_W         = 32;
  localparam int TDATA_W         = 3 * FIELD_W;
  localparam int CFG_W           = 32;
  localparam int CFG_IDX_W       = 3;
  localparam int COORD_WIDTH_DEF = 32;
  localparam int COEF_W          = 16;
  localparam int Q_W             = 16;
  localparam int FRAC_COEF       = 14;

  localparam logic signed [COEF_W-1:0] COS_PITCH = 16'sd15519;
  localparam logic signed [COEF_W-1:0] SIN_PITCH = 16'sd5253;
  localparam logic signed [COEF_W-1:0] COEF_ONE  = 16'sd16384;

  localparam logic [CFG_W-1:0] QUAT_ZW_RST = 32'h4000_0000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MOUNT_X = 3'd0,
    REG_MOUNT_Y = 3'd1,
    REG_MOUNT_Z = 3'd2,
    REG_TRANS_X = 3'd3,
    REG_TRANS_Y = 3'd4,
    REG_TRANS_Z = 3'd5,
    REG_QUAT_XY = 3'd6,
    REG_QUAT_ZW = 3'd7
  } cfg_reg_t;

  typedef struct packed {
    logic signed [COEF_W-1:0] r00;
    logic signed [COEF_W-1:0] r01;
    logic signed [COEF_W-1:0] r02;
    logic signed [COEF_W-1:0] r10;
    logic signed [COEF_W-1:0] r11;
    logic signed [COEF_W-1:0] r12;
    logic signed [COEF_W-1:0] r20;
    logic signed [COEF_W-1:0] r21;
    logic signed [COEF_W-1:0] r22;
  } rot_mat_t;

endpackage

>>> rtl/core/pcrt_pose_matrix.sv
module pcrt_pose_matrix (
  input  logic                          clk,
  input  logic [pcrt_pkg::CFG_W-1:0]    quat_xy,
  input  logic [pcrt_pkg::CFG_W-1:0]    quat_zw,
  output pcrt_pkg::rot_mat_t            mat
);

  localparam int PQ = 2 * pcrt_pkg::Q_W;
  localparam int EW = PQ + 3;
  localparam logic signed [EW-1:0] ONE28 = EW'(2**(2 * pcrt_pkg::FRAC_COEF));
  localparam logic signed [EW-1:0] RND   = EW'(2**(pcrt_pkg::FRAC_COEF - 1));

  logic signed [pcrt_pkg::Q_W-1:0] qx, qy, qz, qw;
  logic signed [PQ-1:0] xx_r, yy_r, zz_r, xy_r, xz_r, yz_r, wx_r, wy_r, wz_r;
  pcrt_pkg::rot_mat_t mat_r, mat_nxt;

  assign qx = quat_xy[pcrt_pkg::Q_W-1:0];
  assign qy = quat_xy[2*pcrt_pkg::Q_W-1:pcrt_pkg::Q_W];
  assign qz = quat_zw[pcrt_pkg::Q_W-1:0];
  assign qw = quat_zw[2*pcrt_pkg::Q_W-1:pcrt_pkg::Q_W];

  function automatic logic signed [pcrt_pkg::COEF_W-1:0] entry14(
    input logic signed [EW-1:0] v
  );
    logic signed [EW-1:0] q;
    logic signed [EW-1:0] one;
    q   = (v + RND) >>> pcrt_pkg::FRAC_COEF;
    one = EW'(pcrt_pkg::COEF_ONE);
    if (q > one) begin
      q = one;
    end else if (q < -one) begin
      q = -one;
    end
    return q[pcrt_pkg::COEF_W-1:0];
  endfunction

  always_ff @(posedge clk) begin
    xx_r <= qx * qx;
    yy_r <= qy * qy;
    zz_r <= qz * qz;
    xy_r <= qx * qy;
    xz_r <= qx * qz;
    yz_r <= qy * qz;
    wx_r <= qw * qx;
    wy_r <= qw * qy;
    wz_r <= qw * qz;
  end

  always_comb begin
    mat_nxt.r00 = entry14(ONE28 - ((EW'(yy_r) + EW'(zz_r)) <<< 1));
    mat_nxt.r01 = entry14((EW'(xy_r) - EW'(wz_r)) <<< 1);
    mat_nxt.r02 = entry14((EW'(xz_r) + EW'(wy_r)) <<< 1);
    mat_nxt.r10 = entry14((EW'(xy_r) + EW'(wz_r)) <<< 1);
    mat_nxt.r11 = entry14(ONE28 - ((EW'(xx_r) + EW'(zz_r)) <<< 1));
    mat_nxt.r12 = entry14((EW'(yz_r) - EW'(wx_r)) <<< 1);
    mat_nxt.r20 = entry14((EW'(xz_r) - EW'(wy_r)) <<< 1);
    mat_nxt.r21 = entry14((EW'(yz_r) + EW'(wx_r)) <<< 1);
    mat_nxt.r22 = entry14(ONE28 - ((EW'(xx_r) + EW'(yy_r)) <<< 1));
  end

  always_ff @(posedge clk) begin
    mat_r <= mat_nxt;
  end

  assign mat = mat_r;

endmodule

>>> rtl/core/pcrt_mount_stage.sv
module pcrt_mount_stage #(
  parameter int CW = pcrt_pkg::COORD_WIDTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic signed [CW-1:0] cam_x,
  input  logic signed [CW-1:0] cam_y,
  input  logic signed [CW-1:0] cam_z,
  input  logic signed [CW-1:0] mount_x,
  input  logic signed [CW-1:0] mount_y,
  input  logic signed [CW-1:0] mount_z,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic signed [CW-1:0] px,
  output logic signed [CW-1:0] py,
  output logic signed [CW-1:0] pz
);

  localparam int PW = CW + pcrt_pkg::COEF_W;
  localparam int SW = CW + 18;
  localparam logic signed [CW-1:0] CMAX = {1'b0, {(CW-1){1'b1}}};
  localparam logic signed [CW-1:0] CMIN = {1'b1, {(CW-1){1'b0}}};
  localparam logic signed [SW-1:0] RND  = SW'(2**(pcrt_pkg::FRAC_COEF - 1));

  logic v0_r, v1_r, v2_r;
  logic en0, en1, en2;

  logic signed [CW-1:0] wx_r, wy_r, wz_r;
  logic signed [CW-1:0] wy_nxt, wz_nxt;
  logic signed [PW-1:0] pa_r, pb_r, pc_r, pd_r;
  logic signed [CW:0]   ysum;
  logic signed [CW-1:0] py1_r, py1_nxt;
  logic signed [SW-1:0] xsum, zsum;
  logic signed [CW-1:0] px_r, py_r, pz_r;

  function automatic logic signed [CW-1:0] floor_sat(input logic signed [SW-1:0] s);
    logic signed [SW-1:0] q;
    q = s >>> pcrt_pkg::FRAC_COEF;
    if (q > SW'(CMAX)) begin
      q = SW'(CMAX);
    end else if (q < SW'(CMIN)) begin
      q = SW'(CMIN);
    end
    return q[CW-1:0];
  endfunction

  assign en2      = !v2_r || out_ready;
  assign en1      = !v1_r || en2;
  assign en0      = !v0_r || en1;
  assign in_ready = en0;

  assign wy_nxt = (cam_x == CMIN) ? CMAX : -cam_x;
  assign wz_nxt = (cam_y == CMIN) ? CMAX : -cam_y;

  assign ysum    = {wy_r[CW-1], wy_r} + {mount_y[CW-1], mount_y};
  assign py1_nxt = (ysum[CW] != ysum[CW-1]) ? (ysum[CW] ? CMIN : CMAX) : ysum[CW-1:0];

  assign xsum = SW'(pa_r) + SW'(pb_r) + (SW'(mount_x) <<< pcrt_pkg::FRAC_COEF) + RND;
  assign zsum = SW'(pd_r) - SW'(pc_r) + (SW'(mount_z) <<< pcrt_pkg::FRAC_COEF) + RND;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      if (en0) v0_r <= in_valid;
      if (en1) v1_r <= v0_r;
      if (en2) v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en0) begin
      wx_r <= cam_z;
      wy_r <= wy_nxt;
      wz_r <= wz_nxt;
    end
    if (en1) begin
      pa_r  <= wx_r * pcrt_pkg::COS_PITCH;
      pb_r  <= wz_r * pcrt_pkg::SIN_PITCH;
      pc_r  <= wx_r * pcrt_pkg::SIN_PITCH;
      pd_r  <= wz_r * pcrt_pkg::COS_PITCH;
      py1_r <= py1_nxt;
    end
    if (en2) begin
      px_r <= floor_sat(xsum);
      py_r <= py1_r;
      pz_r <= floor_sat(zsum);
    end
  end

  assign out_valid = v2_r;
  assign px        = px_r;
  assign py        = py_r;
  assign pz        = pz_r;

endmodule

>>> rtl/core/pcrt_odom_stage.sv
module pcrt_odom_stage #(
  parameter int CW = pcrt_pkg::COORD_WIDTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic signed [CW-1:0] px,
  input  logic signed [CW-1:0] py,
  input  logic signed [CW-1:0] pz,
  input  pcrt_pkg::rot_mat_t   mat,
  input  logic signed [CW-1:0] trans_x,
  input  logic signed [CW-1:0] trans_y,
  input  logic signed [CW-1:0] trans_z,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic signed [CW-1:0] wx,
  output logic signed [CW-1:0] wy,
  output logic signed [CW-1:0] wz
);

  localparam int PW = CW + pcrt_pkg::COEF_W;
  localparam int SW = CW + 18;
  localparam logic signed [CW-1:0] CMAX = {1'b0, {(CW-1){1'b1}}};
  localparam logic signed [CW-1:0] CMIN = {1'b1, {(CW-1){1'b0}}};
  localparam logic signed [SW-1:0] RND  = SW'(2**(pcrt_pkg::FRAC_COEF - 1));

  logic v3_r, v4_r, v5_r;
  logic en3, en4, en5;

  logic signed [pcrt_pkg::COEF_W-1:0] coef [9];
  logic signed [CW-1:0] pt [3];
  logic signed [CW-1:0] tr [3];
  logic signed [PW-1:0] prod_r [9];
  logic signed [SW-1:0] sum_r [3];
  logic signed [CW-1:0] res_r [3];

  function automatic logic signed [CW-1:0] floor_sat(input logic signed [SW-1:0] s);
    logic signed [SW-1:0] q;
    q = s >>> pcrt_pkg::FRAC_COEF;
    if (q > SW'(CMAX)) begin
      q = SW'(CMAX);
    end else if (q < SW'(CMIN)) begin
      q = SW'(CMIN);
    end
    return q[CW-1:0];
  endfunction

  assign coef[0] = mat.r00;
  assign coef[1] = mat.r01;
  assign coef[2] = mat.r02;
  assign coef[3] = mat.r10;
  assign coef[4] = mat.r11;
  assign coef[5] = mat.r12;
  assign coef[6] = mat.r20;
  assign coef[7] = mat.r21;
  assign coef[8] = mat.r22;

  assign pt[0] = px;
  assign pt[1] = py;
  assign pt[2] = pz;
  assign tr[0] = trans_x;
  assign tr[1] = trans_y;
  assign tr[2] = trans_z;

  assign en5      = !v5_r || out_ready;
  assign en4      = !v4_r || en5;
  assign en3      = !v3_r || en4;
  assign in_ready = en3;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else begin
      if (en3) v3_r <= in_valid;
      if (en4) v4_r <= v3_r;
      if (en5) v5_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en3) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          prod_r[3*i+j] <= coef[3*i+j] * pt[j];
        end
      end
    end
    if (en4) begin
      for (int i = 0; i < 3; i++) begin
        sum_r[i] <= SW'(prod_r[3*i]) + SW'(prod_r[3*i+1]) + SW'(prod_r[3*i+2]);
      end
    end
    if (en5) begin
      for (int i = 0; i < 3; i++) begin
        res_r[i] <= floor_sat(sum_r[i] + (SW'(tr[i]) <<< pcrt_pkg::FRAC_COEF) + RND);
      end
    end
  end

  assign out_valid = v5_r;
  assign wx        = res_r[0];
  assign wy        = res_r[1];
  assign wz        = res_r[2];

endmodule

>>> rtl/core/point_cloud_rigid_transform_core.sv
// Camera-to-world point transform.
// The in_ channel takes one camera-frame point per item; the out_ channel gives
// one world-frame point per item, in the same order. Both are tvalid/tready
// streams; an item moves at a clock edge with tvalid and tready high.
// Throughput: one item per cycle while the receiver keeps out_tready high. Each
// item passes six stage registers, each with its valid bit: three of axis
// remap, fixed pitch and mount offset, then three of odometry rotation and
// translation. Configuration goes through cfg_we / cfg_index / cfg_wdata; the
// user must write it only while no item is in flight, as the block does not
// enforce this. A new quaternion reaches the rotation matrix through the
// quaternion, product and matrix registers, ahead of any item that enters after
// the write. Reset (rst_n low, synchronous) empties the pipeline and loads the
// identity pose with zero offsets.
// When the receiver holds out_tready low, the result stays on out_tdata; a stage
// keeps its item only while all later stages are full; in_tready falls only once every stage is full.
module point_cloud_rigid_transform_core #(
  parameter int COORD_WIDTH = pcrt_pkg::COORD_WIDTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [pcrt_pkg::TDATA_W-1:0]      in_tdata,   // cam_x, cam_y, cam_z
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [pcrt_pkg::TDATA_W-1:0]      out_tdata,  // world_x, world_y, world_z
  input  logic                              cfg_we,
  input  logic [pcrt_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [pcrt_pkg::CFG_W-1:0]        cfg_wdata
);

  localparam int FW = pcrt_pkg::FIELD_W;
  localparam int XW = FW + COORD_WIDTH;

  logic [pcrt_pkg::CFG_W-1:0] mount_x_r, mount_y_r, mount_z_r;
  logic [pcrt_pkg::CFG_W-1:0] trans_x_r, trans_y_r, trans_z_r;
  logic [pcrt_pkg::CFG_W-1:0] quat_xy_r, quat_zw_r;

  logic [XW-1:0] cam_x_pad, cam_y_pad, cam_z_pad;
  logic [XW-1:0] mnt_x_pad, mnt_y_pad, mnt_z_pad;
  logic [XW-1:0] trn_x_pad, trn_y_pad, trn_z_pad;
  logic [XW-1:0] out_x_pad, out_y_pad, out_z_pad;

  logic signed [COORD_WIDTH-1:0] cam_x, cam_y, cam_z;
  logic signed [COORD_WIDTH-1:0] mnt_x, mnt_y, mnt_z;
  logic signed [COORD_WIDTH-1:0] trn_x, trn_y, trn_z;
  logic signed [COORD_WIDTH-1:0] px, py, pz;
  logic signed [COORD_WIDTH-1:0] wx, wy, wz;

  logic mid_valid, mid_ready;
  pcrt_pkg::rot_mat_t mat;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mount_x_r <= '0;
      mount_y_r <= '0;
      mount_z_r <= '0;
      trans_x_r <= '0;
      trans_y_r <= '0;
      trans_z_r <= '0;
      quat_xy_r <= '0;
      quat_zw_r <= pcrt_pkg::QUAT_ZW_RST;
    end else if (cfg_we) begin
      case (pcrt_pkg::cfg_reg_t'(cfg_index))
        pcrt_pkg::REG_MOUNT_X: mount_x_r <= cfg_wdata;
        pcrt_pkg::REG_MOUNT_Y: mount_y_r <= cfg_wdata;
        pcrt_pkg::REG_MOUNT_Z: mount_z_r <= cfg_wdata;
        pcrt_pkg::REG_TRANS_X: trans_x_r <= cfg_wdata;
        pcrt_pkg::REG_TRANS_Y: trans_y_r <= cfg_wdata;
        pcrt_pkg::REG_TRANS_Z: trans_z_r <= cfg_wdata;
        pcrt_pkg::REG_QUAT_XY: quat_xy_r <= cfg_wdata;
        pcrt_pkg::REG_QUAT_ZW: quat_zw_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // sign taken from bit COORD_WIDTH-1 of the zero-padded field
  assign cam_x_pad = {{COORD_WIDTH{1'b0}}, in_tdata[FW-1:0]};
  assign cam_y_pad = {{COORD_WIDTH{1'b0}}, in_tdata[2*FW-1:FW]};
  assign cam_z_pad = {{COORD_WIDTH{1'b0}}, in_tdata[3*FW-1:2*FW]};
  assign mnt_x_pad = {{COORD_WIDTH{1'b0}}, mount_x_r};
  assign mnt_y_pad = {{COORD_WIDTH{1'b0}}, mount_y_r};
  assign mnt_z_pad = {{COORD_WIDTH{1'b0}}, mount_z_r};
  assign trn_x_pad = {{COORD_WIDTH{1'b0}}, trans_x_r};
  assign trn_y_pad = {{COORD_WIDTH{1'b0}}, trans_y_r};
  assign trn_z_pad = {{COORD_WIDTH{1'b0}}, trans_z_r};

  assign cam_x = cam_x_pad[COORD_WIDTH-1:0];
  assign cam_y = cam_y_pad[COORD_WIDTH-1:0];
  assign cam_z = cam_z_pad[COORD_WIDTH-1:0];
  assign mnt_x = mnt_x_pad[COORD_WIDTH-1:0];
  assign mnt_y = mnt_y_pad[COORD_WIDTH-1:0];
  assign mnt_z = mnt_z_pad[COORD_WIDTH-1:0];
  assign trn_x = trn_x_pad[COORD_WIDTH-1:0];
  assign trn_y = trn_y_pad[COORD_WIDTH-1:0];
  assign trn_z = trn_z_pad[COORD_WIDTH-1:0];

  pcrt_pose_matrix u_matrix (
    .clk     (clk),
    .quat_xy (quat_xy_r),
    .quat_zw (quat_zw_r),
    .mat     (mat)
  );

  pcrt_mount_stage #(
    .CW (COORD_WIDTH)
  ) u_mount (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .cam_x     (cam_x),
    .cam_y     (cam_y),
    .cam_z     (cam_z),
    .mount_x   (mnt_x),
    .mount_y   (mnt_y),
    .mount_z   (mnt_z),
    .out_valid (mid_valid),
    .out_ready (mid_ready),
    .px        (px),
    .py        (py),
    .pz        (pz)
  );

  pcrt_odom_stage #(
    .CW (COORD_WIDTH)
  ) u_odom (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (mid_valid),
    .in_ready  (mid_ready),
    .px        (px),
    .py        (py),
    .pz        (pz),
    .mat       (mat),
    .trans_x   (trn_x),
    .trans_y   (trn_y),
    .trans_z   (trn_z),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .wx        (wx),
    .wy        (wy),
    .wz        (wz)
  );

  assign out_x_pad = {{FW{1'b0}}, wx};
  assign out_y_pad = {{FW{1'b0}}, wy};
  assign out_z_pad = {{FW{1'b0}}, wz};

  assign out_tdata = {out_z_pad[FW-1:0], out_y_pad[FW-1:0], out_x_pad[FW-1:0]};

endmodule

>>> rtl/core/pcrt_checker.sv
module pcrt_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_tvalid,
  input logic                          in_tready,
  input logic [pcrt_pkg::TDATA_W-1:0]  in_tdata,
  input logic                          out_tvalid,
  input logic                          out_tready,
  input logic [pcrt_pkg::TDATA_W-1:0]  out_tdata
);

  logic in_seen;

  assign in_seen = in_tvalid && in_tready && (in_tdata == in_tdata);

  // reset leaves no result on the output
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid ##1 !out_tvalid)
    else $error("result shown too soon after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");

  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_tvalid || out_tready) |-> in_tready)
    else $error("input held back while output slot free");

  a_no_early: assert property (@(posedge clk) disable iff (!rst_n)
    !in_seen && !out_tvalid |=> !out_tvalid || $past(in_tready))
    else $error("result appeared from an empty pipeline stall");

endmodule

bind point_cloud_rigid_transform_core pcrt_checker u_pcrt_checker (.*);

>>> tb/sv/tb.sv
`timescale 1ns / 100ps

module tb;
  import pcrt_pkg::*;

  typedef struct packed {
    logic signed [FIELD_W-1:0] z;
    logic signed [FIELD_W-1:0] y;
    logic signed [FIELD_W-1:0] x;
  } point_t;

  localparam longint COORD_MAX   = (longint'(1) <<< (FIELD_W - 1)) - 1;
  localparam longint COORD_MIN   = -COORD_MAX - 1;
  localparam longint ROUND_HALF  = longint'(1) <<< (FRAC_COEF - 1);
  localparam longint UNIT_Q14    = longint'(1) <<< FRAC_COEF;
  localparam longint UNIT_Q28    = longint'(1) <<< (2 * FRAC_COEF);
  localparam int     HOLD_CYCLES = 300;
  localparam int     QUIET_LIMIT = 10000;
  localparam int     DRAIN_WAIT  = 12;
  localparam int     PHASE_ITEMS = 75;

  localparam logic [FIELD_W-1:0] C_MAX = 32'h7fff_ffff;
  localparam logic [FIELD_W-1:0] C_MIN = 32'h8000_0000;
  localparam logic [FIELD_W-1:0] ONE_M = 32'h0001_0000;

  logic                 clk        = 1'b0;
  logic                 rst_n      = 1'b0;
  logic                 in_tvalid  = 1'b0;
  logic                 in_tready;
  logic [TDATA_W-1:0]   in_tdata   = '0;
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [TDATA_W-1:0]   out_tdata;
  logic                 cfg_we     = 1'b0;
  cfg_reg_t             cfg_index  = REG_MOUNT_X;
  logic [CFG_W-1:0]     cfg_wdata  = '0;

  logic [CFG_W-1:0] pose_regs [8];
  point_t           pending_points [$];
  point_t           expected_world [$];
  int               send_idle_pct  = 0;
  int               recv_stall_pct = 0;
  int               hold_token     = 0;
  int               hold_seen      = 0;
  int               hold_left      = 0;
  int               quiet_cycles   = 0;
  int               mismatches     = 0;

  point_cloud_rigid_transform_core i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always #6 clk = ~clk;

  function automatic longint clip_coord(longint v);
    if (v > COORD_MAX) return COORD_MAX;
    if (v < COORD_MIN) return COORD_MIN;
    return v;
  endfunction

  function automatic longint dot3_round(longint a, longint b, longint c,
                                        longint p0, longint p1, longint p2,
                                        longint off);
    longint acc;
    acc = a * p0 + b * p1 + c * p2 + off * UNIT_Q14 + ROUND_HALF;
    return clip_coord(acc >>> FRAC_COEF);
  endfunction

  function automatic longint coef_of(longint v28);
    longint r;
    r = (v28 + ROUND_HALF) >>> FRAC_COEF;
    if (r > UNIT_Q14) return UNIT_Q14;
    if (r < -UNIT_Q14) return -UNIT_Q14;
    return r;
  endfunction

  function automatic longint reg_coord(cfg_reg_t idx);
    return longint'($signed(pose_regs[idx]));
  endfunction

  function automatic point_t world_of(point_t cam);
    longint wx, wy, wz, px, py, pz;
    longint qx, qy, qz, qw;
    longint m [3][3];
    longint cs, sn;
    point_t res;
    qx = longint'($signed(pose_regs[REG_QUAT_XY][15:0]));
    qy = longint'($signed(pose_regs[REG_QUAT_XY][31:16]));
    qz = longint'($signed(pose_regs[REG_QUAT_ZW][15:0]));
    qw = longint'($signed(pose_regs[REG_QUAT_ZW][31:16]));
    cs = longint'(COS_PITCH);
    sn = longint'(SIN_PITCH);
    wx = longint'(cam.z);
    wy = clip_coord(-longint'(cam.x));
    wz = clip_coord(-longint'(cam.y));
    px = dot3_round(cs, 0, sn, wx, wy, wz, reg_coord(REG_MOUNT_X));
    py = clip_coord(wy + reg_coord(REG_MOUNT_Y));
    pz = dot3_round(-sn, 0, cs, wx, wy, wz, reg_coord(REG_MOUNT_Z));
    m[0][0] = coef_of(UNIT_Q28 - 2 * (qy * qy + qz * qz));
    m[0][1] = coef_of(2 * (qx * qy - qw * qz));
    m[0][2] = coef_of(2 * (qx * qz + qw * qy));
    m[1][0] = coef_of(2 * (qx * qy + qw * qz));
    m[1][1] = coef_of(UNIT_Q28 - 2 * (qx * qx + qz * qz));
    m[1][2] = coef_of(2 * (qy * qz - qw * qx));
    m[2][0] = coef_of(2 * (qx * qz - qw * qy));
    m[2][1] = coef_of(2 * (qy * qz + qw * qx));
    m[2][2] = coef_of(UNIT_Q28 - 2 * (qx * qx + qy * qy));
    res.x = FIELD_W'(dot3_round(m[0][0], m[0][1], m[0][2], px, py, pz,
                                reg_coord(REG_TRANS_X)));
    res.y = FIELD_W'(dot3_round(m[1][0], m[1][1], m[1][2], px, py, pz,
                                reg_coord(REG_TRANS_Y)));
    res.z = FIELD_W'(dot3_round(m[2][0], m[2][1], m[2][2], px, py, pz,
                                reg_coord(REG_TRANS_Z)));
    return res;
  endfunction

  function automatic point_t mk_point(logic [FIELD_W-1:0] x, logic [FIELD_W-1:0] y,
                                      logic [FIELD_W-1:0] z);
    point_t p;
    p.x = x;
    p.y = y;
    p.z = z;
    return p;
  endfunction

  function automatic logic [FIELD_W-1:0] pick_coord(int kind);
    if (kind < 5) return FIELD_W'(int'($urandom_range(1310720)) - 655360);
    if (kind < 8) return $urandom;
    case ($urandom_range(5))
      0: return C_MAX;
      1: return C_MIN;
      2: return '0;
      3: return '1;
      4: return FIELD_W'(1);
      default: return $urandom;
    endcase
  endfunction

  function automatic point_t rand_point();
    int kind;
    kind = $urandom_range(9);
    return mk_point(pick_coord(kind), pick_coord(kind), pick_coord(kind));
  endfunction

  task automatic queue_point(point_t p);
    pending_points.insert(pending_points.size(), p);
  endtask

  task automatic unit_quat(output logic [CFG_W-1:0] xy, output logic [CFG_W-1:0] zw);
    real q [4];
    real n;
    int  c [4];
    n = 0.0;
    for (int i = 0; i < 4; i++) begin
      q[i] = real'(int'($urandom_range(32768)) - 16384);
      n += q[i] * q[i];
    end
    if (n < 1.0) begin
      q[3] = 1.0;
      n = 1.0;
    end
    n = $sqrt(n);
    for (int i = 0; i < 4; i++) c[i] = int'(q[i] / n * 16384.0);
    xy = {c[1][15:0], c[0][15:0]};
    zw = {c[3][15:0], c[2][15:0]};
  endtask

  task automatic load_reg(cfg_reg_t idx, logic [CFG_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    pose_regs[idx] = val;
  endtask

  task automatic apply_pose(input logic [CFG_W-1:0] vals [8]);
    cfg_reg_t idx;
    idx = idx.first();
    for (int i = 0; i < 8; i++) begin
      load_reg(idx, vals[i]);
      idx = idx.next();
    end
    @(posedge clk);
    cfg_we <= 1'b0;
    repeat (3) @(posedge clk);
  endtask

  task automatic wait_idle();
    while (pending_points.size() != 0 || in_tvalid || expected_world.size() != 0)
      @(negedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic check_field(string name, logic [FIELD_W-1:0] exp_v,
                             logic [FIELD_W-1:0] got_v);
    if (exp_v !== got_v) begin
      $error("%s mismatch: expected %0d, got %0d", name, $signed(exp_v), $signed(got_v));
      mismatches++;
    end
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready)
        expected_world.insert(expected_world.size(), world_of(point_t'(in_tdata)));
      if (!in_tvalid || in_tready) begin
        if (pending_points.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          in_tvalid <= 1'b1;
          in_tdata  <= pending_points.pop_front();
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_token != hold_seen) begin
      hold_seen  <= hold_token;
      hold_left  <= HOLD_CYCLES;
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left  <= hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // monitor
  always @(posedge clk) begin
    point_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata;
      if (expected_world.size() == 0) begin
        $error("unexpected item: world_x %0d world_y %0d world_z %0d", got.x, got.y, got.z);
        mismatches++;
      end else begin
        want = expected_world.pop_front();
        check_field("world_x", want.x, got.x);
        check_field("world_y", want.y, got.y);
        check_field("world_z", want.z, got.z);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    logic [CFG_W-1:0] pose [8];
    logic [CFG_W-1:0] qa, qb;
    int mode;
    int idle;
    for (int i = 0; i < 8; i++) pose_regs[i] = '0;
    pose_regs[REG_QUAT_ZW] = QUAT_ZW_RST;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    queue_point(mk_point('0, '0, '0));
    queue_point(mk_point(C_MAX, '0, '0));
    queue_point(mk_point(C_MIN, '0, '0));
    queue_point(mk_point('0, C_MAX, '0));
    queue_point(mk_point('0, C_MIN, '0));
    queue_point(mk_point('0, '0, C_MAX));
    queue_point(mk_point('0, '0, C_MIN));
    queue_point(mk_point(C_MAX, C_MAX, C_MAX));
    queue_point(mk_point(C_MIN, C_MIN, C_MIN));
    queue_point(mk_point(C_MAX, C_MIN, C_MAX));
    queue_point(mk_point(C_MIN, C_MAX, C_MIN));
    queue_point(mk_point(ONE_M, ONE_M, ONE_M));
    queue_point(mk_point(-ONE_M, -ONE_M, -ONE_M));
    queue_point(mk_point(32'd1, '1, 32'd1));
    queue_point(mk_point('1, '1, '1));
    queue_point(mk_point(32'h5555_5555, 32'haaaa_aaaa, 32'h5555_5555));
    queue_point(mk_point(32'haaaa_aaaa, 32'h5555_5555, 32'haaaa_aaaa));
    wait_idle();

    for (int ph = 0; ph < 8; ph++) begin
      mode = ph % 4;
      idle = (ph + ph / 4) % 4;
      case (mode)
        0, 3: begin
          for (int i = 0; i < 6; i++) begin
            if (mode == 0) pose[i] = CFG_W'(int'($urandom_range(524288)) - 262144);
            else           pose[i] = CFG_W'(int'($urandom_range(131072000)) - 65536000);
          end
          unit_quat(qa, qb);
          pose[REG_QUAT_XY] = qa;
          pose[REG_QUAT_ZW] = qb;
        end
        1: begin
          for (int i = 0; i < 6; i++) pose[i] = (ph < 4) ? C_MAX : C_MIN;
          pose[REG_QUAT_XY] = (ph < 4) ? 32'h7fff_7fff : 32'h8000_8000;
          pose[REG_QUAT_ZW] = (ph < 4) ? 32'h7fff_7fff : 32'h8000_8000;
        end
        default: begin
          for (int i = 0; i < 8; i++) pose[i] = $urandom;
        end
      endcase
      apply_pose(pose);
      send_idle_pct  = (idle == 1) ? 46 : (idle == 3) ? 29 : 0;
      recv_stall_pct = (idle == 2) ? 46 : (idle == 3) ? 29 : 0;
      if (ph == 0) hold_token++;
      for (int n = 0; n < PHASE_ITEMS; n++) queue_point(rand_point());
      wait_idle();
    end

    if (mismatches == 0 && expected_world.size() == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
